/* rtl/core/som_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the self-organizing map winner search block.
// Used by the controller, the datapath and the top level; depends on nothing.
package som_pkg;

   localparam int MAX_UNITS_DEF = 256;
   localparam int MAX_DIMS_DEF  = 64;

   localparam int UNIT_IN_W   = 8;
   localparam int DIM_IN_W    = 6;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int COORD_W     = 8;
   localparam int DIST_W      = 38;
   localparam int SQ_W        = 32;
   localparam int UNITS_CFG_W = 9;
   localparam int DIMS_CFG_W  = 7;
   localparam int WIDTH_CFG_W = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   localparam int UNITS_RESET     = 256;
   localparam int DIMS_RESET      = 64;
   localparam int MAP_WIDTH_RESET = 16;

   localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_UPDATE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RSP_ACK  = 2'd0,
      RSP_WIN  = 2'd1,
      RSP_READ = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_UNITS     = 2'd0,
      CSR_DIMS      = 2'd1,
      CSR_MAP_WIDTH = 2'd2
   } csr_type;

   typedef struct packed {
      logic     capture;
      logic     cb_write;
      logic     obs_write;
      logic     rd_single;
      logic     walk;
      logic     search;
      logic     div_start;
      logic     load_rsp;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic walk_last;
      logic pipe_idle;
      logic div_busy;
   } status_type;

endpackage

/* rtl/core/som_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; used for the codebook and the observation buffer.
module som_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/som_div.sv */
`timescale 1ns / 1ps
// Restoring divider that yields one quotient bit per cycle.
// Stands alone; turns the winner index into grid row and column.
module som_div #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem,
   output logic             busy
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DEN_W'(trial - {1'b0, den_ff});
            quot_in = NUM_W'({quot_ff, 1'b1});
         end else begin
            rem_in  = DEN_W'(trial);
            quot_in = NUM_W'({quot_ff, 1'b0});
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;
   assign busy = busy_ff;

endmodule

/* rtl/core/som_dp.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, codebook and observation memories, distance
// and update pipeline, winner tracking and result register. Uses som_pkg, som_ram, som_div.
module som_dp #(
   parameter int MAX_UNITS = som_pkg::MAX_UNITS_DEF,
   parameter int MAX_DIMS  = som_pkg::MAX_DIMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  som_pkg::cmd_type                    cmd,
   output som_pkg::status_type                 status,
   input  logic [1:0]                          req_op,
   input  logic [som_pkg::UNIT_IN_W-1:0]       req_unit,
   input  logic [som_pkg::DIM_IN_W-1:0]        req_dim,
   input  logic signed [som_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic [som_pkg::GAIN_W-1:0]          req_gain,
   input  logic                                csr_write_enable,
   input  logic [som_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [som_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic [1:0]                          rsp_result_kind,
   output logic [som_pkg::COORD_W-1:0]         rsp_winner_unit,
   output logic [som_pkg::COORD_W-1:0]         rsp_winner_x,
   output logic [som_pkg::COORD_W-1:0]         rsp_winner_y,
   output logic [som_pkg::DIST_W-1:0]          rsp_sq_distance,
   output logic signed [som_pkg::SAMPLE_W-1:0] rsp_read_value
);

   localparam int UNIT_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DEPTH  = MAX_UNITS * MAX_DIMS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ACC_W  = som_pkg::SQ_W + DIM_W;
   localparam int SW     = som_pkg::SAMPLE_W;

   logic [som_pkg::UNITS_CFG_W-1:0] units_ff, units_in;
   logic [som_pkg::DIMS_CFG_W-1:0]  dims_ff, dims_in;
   logic [som_pkg::WIDTH_CFG_W-1:0] map_width_ff, map_width_in;
   logic [UNIT_W-1:0]               units_last;
   logic [DIM_W-1:0]                dims_last;
   logic [som_pkg::WIDTH_CFG_W-1:0] den_eff;

   logic                         unit_ok_ff, unit_ok_in;
   logic                         dim_ok_ff, dim_ok_in;
   logic [som_pkg::DIM_IN_W-1:0] dim_ff, dim_in;
   logic [SW-1:0]                sample_ff, sample_in;
   logic [som_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   logic [ADDR_W-1:0]            base_ff, base_in;
   logic [UNIT_W-1:0]            u_cnt_ff, u_cnt_in;
   logic [DIM_W-1:0]             d_cnt_ff, d_cnt_in;
   logic [ADDR_W-1:0]            single_addr;
   logic [ADDR_W-1:0]            walk_addr;

   logic              cb_we, cb_re;
   logic [ADDR_W-1:0] cb_waddr, cb_raddr;
   logic [SW-1:0]     cb_wdata, cb_rdata;
   logic              obs_we;
   logic [SW-1:0]     obs_rdata;

   logic              v1_ff, upd1_ff, first1_ff, eou1_ff;
   logic [UNIT_W-1:0] unit1_ff;
   logic [ADDR_W-1:0] addr1_ff;
   logic              v2_ff, upd2_ff, first2_ff, eou2_ff;
   logic [UNIT_W-1:0] unit2_ff;
   logic [ADDR_W-1:0] addr2_ff;
   logic [SW-1:0]     c2_ff;
   logic signed [2*SW+1:0] prod_ff, prod_in;
   logic signed [SW:0]     diff, mult_b;
   logic [SW-1:0]          upd_value;
   logic                   upd_we;

   logic              v3_ff, v3_in;
   logic [UNIT_W-1:0] unit3_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  best_ff, best_in;
   logic [UNIT_W-1:0] best_unit_ff, best_unit_in;

   logic [UNIT_W-1:0]               quot;
   logic [som_pkg::WIDTH_CFG_W-1:0] rem;
   logic                            div_busy;

   som_pkg::kind_type              kind_ff;
   logic [som_pkg::COORD_W-1:0]    win_unit_ff, win_x_ff, win_y_ff;
   logic [som_pkg::DIST_W-1:0]     dist_ff, dist_sat;
   logic [SW-1:0]                  read_ff;

   always_comb begin
      units_in     = units_ff;
      dims_in      = dims_ff;
      map_width_in = map_width_ff;
      if (csr_write_enable) begin
         unique case (som_pkg::csr_type'(csr_index))
            som_pkg::CSR_UNITS:     units_in = som_pkg::UNITS_CFG_W'(csr_write_data);
            som_pkg::CSR_DIMS:      dims_in = som_pkg::DIMS_CFG_W'(csr_write_data);
            som_pkg::CSR_MAP_WIDTH: map_width_in = som_pkg::WIDTH_CFG_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      if (units_ff == '0) begin
         units_last = '0;
      end else if (int'(units_ff) > MAX_UNITS) begin
         units_last = UNIT_W'(MAX_UNITS - 1);
      end else begin
         units_last = UNIT_W'(units_ff - 1'b1);
      end
      if (dims_ff == '0) begin
         dims_last = '0;
      end else if (int'(dims_ff) > MAX_DIMS) begin
         dims_last = DIM_W'(MAX_DIMS - 1);
      end else begin
         dims_last = DIM_W'(dims_ff - 1'b1);
      end
      den_eff = (map_width_ff == '0) ? som_pkg::WIDTH_CFG_W'(1) : map_width_ff;
   end

   assign single_addr = ADDR_W'(base_ff + ADDR_W'(dim_ff));
   assign walk_addr   = ADDR_W'(base_ff + ADDR_W'(d_cnt_ff));

   always_comb begin
      unit_ok_in = unit_ok_ff;
      dim_ok_in  = dim_ok_ff;
      dim_in     = dim_ff;
      sample_in  = sample_ff;
      gain_in    = gain_ff;
      base_in    = base_ff;
      u_cnt_in   = u_cnt_ff;
      d_cnt_in   = d_cnt_ff;
      if (cmd.capture) begin
         unit_ok_in = int'(req_unit) < MAX_UNITS;
         dim_ok_in  = int'(req_dim) < MAX_DIMS;
         dim_in     = req_dim;
         sample_in  = req_sample_value;
         gain_in    = req_gain;
         base_in    = (req_op == som_pkg::OP_LOAD) ? '0 : ADDR_W'(int'(req_unit) * MAX_DIMS);
         u_cnt_in   = '0;
         d_cnt_in   = '0;
      end else if (cmd.walk) begin
         if (d_cnt_ff == dims_last) begin
            d_cnt_in = '0;
            if (cmd.search) begin
               u_cnt_in = u_cnt_ff + 1'b1;
               base_in  = ADDR_W'(base_ff + ADDR_W'(MAX_DIMS));
            end
         end else begin
            d_cnt_in = d_cnt_ff + 1'b1;
         end
      end
   end

   assign cb_re    = cmd.rd_single ? (unit_ok_ff && dim_ok_ff)
                                   : (cmd.walk && (cmd.search || unit_ok_ff));
   assign cb_raddr = cmd.rd_single ? single_addr : walk_addr;

   assign diff      = $signed({obs_rdata[SW-1], obs_rdata}) - $signed({cb_rdata[SW-1], cb_rdata});
   assign mult_b    = upd1_ff ? $signed({1'b0, gain_ff}) : diff;
   assign prod_in   = diff * mult_b;
   assign upd_value = SW'($signed(c2_ff) + $signed(SW'(prod_ff >>> 16)));
   assign upd_we    = v2_ff && upd2_ff && unit_ok_ff;

   assign cb_we    = (cmd.cb_write && unit_ok_ff && dim_ok_ff) || upd_we;
   assign cb_waddr = cmd.cb_write ? single_addr : addr2_ff;
   assign cb_wdata = cmd.cb_write ? sample_ff : upd_value;
   assign obs_we   = cmd.obs_write && dim_ok_ff;

   som_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_codebook (
      .clock   (clock),
      .wr_en   (cb_we),
      .wr_addr (cb_waddr),
      .wr_data (cb_wdata),
      .rd_en   (cb_re),
      .rd_addr (cb_raddr),
      .rd_data (cb_rdata)
   );

   som_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_DIMS)
   ) u_observation (
      .clock   (clock),
      .wr_en   (obs_we),
      .wr_addr (DIM_W'(dim_ff)),
      .wr_data (sample_ff),
      .rd_en   (cmd.walk),
      .rd_addr (d_cnt_ff),
      .rd_data (obs_rdata)
   );

   always_comb begin
      acc_in       = acc_ff;
      v3_in        = 1'b0;
      best_in      = best_ff;
      best_unit_in = best_unit_ff;
      if (v2_ff && !upd2_ff) begin
         acc_in = (first2_ff ? '0 : acc_ff) + ACC_W'(prod_ff[som_pkg::SQ_W-1:0]);
         v3_in  = eou2_ff;
      end
      if (v3_ff && ((unit3_ff == '0) || (acc_ff < best_ff))) begin
         best_in      = acc_ff;
         best_unit_in = unit3_ff;
      end
   end

   som_div #(
      .NUM_W (UNIT_W),
      .DEN_W (som_pkg::WIDTH_CFG_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (best_unit_ff),
      .den   (den_eff),
      .quot  (quot),
      .rem   (rem),
      .busy  (div_busy)
   );

   assign dist_sat = (64'(best_ff) > som_pkg::DIST_MAX) ? som_pkg::DIST_W'(som_pkg::DIST_MAX)
                                                        : som_pkg::DIST_W'(best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff     <= som_pkg::UNITS_CFG_W'(som_pkg::UNITS_RESET);
         dims_ff      <= som_pkg::DIMS_CFG_W'(som_pkg::DIMS_RESET);
         map_width_ff <= som_pkg::WIDTH_CFG_W'(som_pkg::MAP_WIDTH_RESET);
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         units_ff     <= units_in;
         dims_ff      <= dims_in;
         map_width_ff <= map_width_in;
         v1_ff        <= cmd.walk;
         v2_ff        <= v1_ff;
         v3_ff        <= v3_in;
      end
      unit_ok_ff   <= unit_ok_in;
      dim_ok_ff    <= dim_ok_in;
      dim_ff       <= dim_in;
      sample_ff    <= sample_in;
      gain_ff      <= gain_in;
      base_ff      <= base_in;
      u_cnt_ff     <= u_cnt_in;
      d_cnt_ff     <= d_cnt_in;
      upd1_ff      <= !cmd.search;
      first1_ff    <= d_cnt_ff == '0;
      eou1_ff      <= d_cnt_ff == dims_last;
      unit1_ff     <= u_cnt_ff;
      addr1_ff     <= walk_addr;
      upd2_ff      <= upd1_ff;
      first2_ff    <= first1_ff;
      eou2_ff      <= eou1_ff;
      unit2_ff     <= unit1_ff;
      addr2_ff     <= addr1_ff;
      c2_ff        <= cb_rdata;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      unit3_ff     <= unit2_ff;
      best_ff      <= best_in;
      best_unit_ff <= best_unit_in;
      if (cmd.load_rsp) begin
         kind_ff <= cmd.kind;
         if (cmd.kind == som_pkg::RSP_WIN) begin
            win_unit_ff <= som_pkg::COORD_W'(best_unit_ff);
            win_x_ff    <= som_pkg::COORD_W'(rem);
            win_y_ff    <= som_pkg::COORD_W'(quot);
            dist_ff     <= dist_sat;
         end else begin
            win_unit_ff <= '0;
            win_x_ff    <= '0;
            win_y_ff    <= '0;
            dist_ff     <= '0;
         end
         if (cmd.kind == som_pkg::RSP_READ && unit_ok_ff && dim_ok_ff) begin
            read_ff <= cb_rdata;
         end else begin
            read_ff <= '0;
         end
      end
   end

   assign status.walk_last = (d_cnt_ff == dims_last) && (!cmd.search || (u_cnt_ff == units_last));
   assign status.pipe_idle = !v1_ff && !v2_ff && !v3_ff;
   assign status.div_busy  = div_busy;

   assign rsp_result_kind = kind_ff;
   assign rsp_winner_unit = win_unit_ff;
   assign rsp_winner_x    = win_x_ff;
   assign rsp_winner_y    = win_y_ff;
   assign rsp_sq_distance = dist_ff;
   assign rsp_read_value  = read_ff;

endmodule

/* rtl/core/som_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences each item through the datapath and owns
// the request and result handshakes. Uses som_pkg.
module som_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic                req_last_element,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output som_pkg::cmd_type    cmd,
   input  som_pkg::status_type status
);

   typedef enum logic [10:0] {
      ST_IDLE         = 11'b00000000001,
      ST_CB_WRITE     = 11'b00000000010,
      ST_OBS_WRITE    = 11'b00000000100,
      ST_READ         = 11'b00000001000,
      ST_SEARCH       = 11'b00000010000,
      ST_SEARCH_DRAIN = 11'b00000100000,
      ST_UPDATE       = 11'b00001000000,
      ST_UPDATE_DRAIN = 11'b00010000000,
      ST_DIV_START    = 11'b00100000000,
      ST_DIV_WAIT     = 11'b01000000000,
      ST_DONE         = 11'b10000000000
   } state_type;

   state_type         state_ff, state_in;
   som_pkg::kind_type kind_ff, kind_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.kind     = kind_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               kind_in     = som_pkg::RSP_ACK;
               unique case (som_pkg::op_type'(req_op))
                  som_pkg::OP_WRITE: state_in = ST_CB_WRITE;
                  som_pkg::OP_LOAD: begin
                     state_in = ST_OBS_WRITE;
                     if (req_last_element) begin
                        kind_in = som_pkg::RSP_WIN;
                     end
                  end
                  som_pkg::OP_UPDATE: state_in = ST_UPDATE;
                  som_pkg::OP_READ: begin
                     state_in = ST_READ;
                     kind_in  = som_pkg::RSP_READ;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CB_WRITE: begin
            cmd.cb_write = 1'b1;
            state_in     = ST_DONE;
         end
         ST_OBS_WRITE: begin
            cmd.obs_write = 1'b1;
            state_in      = (kind_ff == som_pkg::RSP_WIN) ? ST_SEARCH : ST_DONE;
         end
         ST_READ: begin
            cmd.rd_single = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SEARCH: begin
            cmd.walk   = 1'b1;
            cmd.search = 1'b1;
            if (status.walk_last) begin
               state_in = ST_SEARCH_DRAIN;
            end
         end
         ST_SEARCH_DRAIN: begin
            if (status.pipe_idle) begin
               state_in = ST_DIV_START;
            end
         end
         ST_UPDATE: begin
            cmd.walk = 1'b1;
            if (status.walk_last) begin
               state_in = ST_UPDATE_DRAIN;
            end
         end
         ST_UPDATE_DRAIN: begin
            if (status.pipe_idle) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= som_pkg::RSP_ACK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/som_winner_search_and_update.sv */
`timescale 1ns / 1ps
// Top level of the self-organizing map winner search and update block.
// Joins som_ctrl and som_dp; uses som_pkg.
//
// One item is worked on at a time, and the result register lets a new item be
// accepted while the previous result waits. A codebook write, an observation load
// that is not the last element and a codebook read each use one working state
// between the capture and the done state. An update walks the dims_in_use elements
// of one unit and drains the pipeline. A load that ends an observation starts the
// search over units_in_use * dims_in_use elements, a drain and a division: the codebook
// read port delivers one element per cycle and the grid row and column come from a
// divider that makes one bit per cycle. The memories need no clearing pass after reset.
module som_winner_search_and_update #(
   parameter int MAX_UNITS = som_pkg::MAX_UNITS_DEF,
   parameter int MAX_DIMS  = som_pkg::MAX_DIMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [som_pkg::UNIT_IN_W-1:0]       req_unit,
   input  logic [som_pkg::DIM_IN_W-1:0]        req_dim,
   input  logic signed [som_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic [som_pkg::GAIN_W-1:0]          req_gain,
   input  logic                                req_last_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_result_kind,
   output logic [som_pkg::COORD_W-1:0]         rsp_winner_unit,
   output logic [som_pkg::COORD_W-1:0]         rsp_winner_x,
   output logic [som_pkg::COORD_W-1:0]         rsp_winner_y,
   output logic [som_pkg::DIST_W-1:0]          rsp_sq_distance,
   output logic signed [som_pkg::SAMPLE_W-1:0] rsp_read_value,
   input  logic                                csr_write_enable,
   input  logic [som_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [som_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   som_pkg::cmd_type    cmd;
   som_pkg::status_type status;

   som_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status)
   );

   som_dp #(
      .MAX_UNITS (MAX_UNITS),
      .MAX_DIMS  (MAX_DIMS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_unit         (req_unit),
      .req_dim          (req_dim),
      .req_sample_value (req_sample_value),
      .req_gain         (req_gain),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_winner_unit  (rsp_winner_unit),
      .rsp_winner_x     (rsp_winner_x),
      .rsp_winner_y     (rsp_winner_y),
      .rsp_sq_distance  (rsp_sq_distance),
      .rsp_read_value   (rsp_read_value)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block did not go busy after taking an item");

   a_load_when_settled: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.pipe_idle && !status.div_busy)
      else $error("result loaded before the pipeline and divider settled");

   a_winner_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != som_pkg::RSP_WIN) |->
         (rsp_sq_distance == '0) && (rsp_winner_unit == '0) &&
         (rsp_winner_x == '0) && (rsp_winner_y == '0))
      else $error("winner fields set in a result that is not a winner");

endmodule
